FILE: src/first_fit_heap_allocator_core_assert.svh
// Assertion macros used by the allocator back end.
// Include guard, so the macros are defined once per compilation unit.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH

// Property checked on every rising clock edge while reset is released.
`define FFHA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, including during reset.
`define FFHA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and fixed field widths shared by the first-fit allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

    // Field widths of the request, response and configuration transactions.
    localparam int REQ_W     = 15;
    localparam int HANDLE_W  = 12;
    localparam int OFFS_W    = 12;
    localparam int LARGEST_W = 15;
    localparam int CFG_W     = 13;
    localparam int WORDS_W   = 13;
    localparam int WORD_SH   = 3;

    // Reset value of the pool size register.
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4096);

    typedef enum logic [1:0] {
        MODE_INIT  = 2'd0,
        MODE_ALLOC = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        mode_t                 mode;
        logic [WORDS_W-1:0]    words;
        logic [HANDLE_W-1:0]   handle;
    } cmd_t;

endpackage

`default_nettype wire

FILE: src/ffha_if.sv
// ----------------------------------------------------------------------------
// ffha_if
// Valid/ready channel interfaces for allocator requests and responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ffha_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic [ffha_pkg::REQ_W-1:0]    request_bytes;
    logic [ffha_pkg::HANDLE_W-1:0] handle;

    modport source (output valid, mode, request_bytes, handle, input ready);
    modport sink   (input valid, mode, request_bytes, handle, output ready);
endinterface

interface ffha_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           ok;
    logic [ffha_pkg::OFFS_W-1:0]    block_offset;
    logic [ffha_pkg::LARGEST_W-1:0] largest_bytes;

    modport source (output valid, ok, block_offset, largest_bytes, input ready);
    modport sink   (input valid, ok, block_offset, largest_bytes, output ready);
endinterface

`default_nettype wire

FILE: src/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/ffha_front.sv
// ----------------------------------------------------------------------------
// ffha_front
// Accepts request transactions and classifies them into commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffha_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    ffha_req_if.sink            req,
    output ffha_pkg::cmd_t      cmd,
    output logic                cmd_valid,
    input  wire logic           cmd_ready
);
    import ffha_pkg::*;

    logic                full_reg;
    cmd_t                cmd_reg;
    logic [REQ_W:0]      req_round;
    cmd_t                cmd_in;

    // Round the byte count up to whole 8-byte words.
    assign req_round = {1'b0, req.request_bytes} + (REQ_W+1)'(7);

    always_comb
    begin
        cmd_in.mode   = mode_t'(req.mode);
        cmd_in.words  = WORDS_W'(req_round >> WORD_SH);
        cmd_in.handle = req.handle;
    end

    assign req.ready = !full_reg || cmd_ready;
    assign cmd_valid = full_reg;
    assign cmd       = cmd_reg;

    // Holding stage in front of the command queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            full_reg <= 1'b1;
        end
        else if (cmd_ready)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg <= cmd_in;
        end
    end

endmodule

`default_nettype wire

FILE: src/ffha_fifo.sv
// ----------------------------------------------------------------------------
// ffha_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffha_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ffha_pkg::cmd_t push_cmd,
    input  wire logic           push_valid,
    output logic                push_ready,
    output ffha_pkg::cmd_t      pop_cmd,
    output logic                pop_valid,
    input  wire logic           pop
);
    import ffha_pkg::*;

    cmd_t       entry_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointer and occupancy bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: src/ffha_back.sv
// ----------------------------------------------------------------------------
// ffha_back
// Walks and rewrites the block headers held in RAM, one command at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_heap_allocator_core_assert.svh"

module ffha_back #(
    parameter int POOL_WORDS = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire ffha_pkg::cmd_t           cmd,
    input  wire logic                     cmd_valid,
    output logic                          cmd_pop,
    input  wire logic [ffha_pkg::CFG_W-1:0] pool_words,
    ffha_rsp_if.source                    rsp
);
    import ffha_pkg::*;

    localparam int ADDR_W = $clog2(POOL_WORDS);
    localparam int H_W    = ADDR_W + 2;
    localparam int P_W    = ADDR_W + 3;
    localparam int R_W    = ((H_W > WORDS_W) ? H_W : WORDS_W) + 2;
    localparam int C_W    = (P_W > CFG_W) ? P_W : CFG_W;

    localparam logic signed [H_W-1:0] END_MARK = {1'b1, {(H_W-1){1'b0}}};
    localparam logic [P_W-1:0]        POOL_P   = P_W'(POOL_WORDS);
    localparam logic [C_W-1:0]        POOL_C   = C_W'(POOL_WORDS);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT_WR2,
        ST_FREE_CHK,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_MERGE_RD,
        ST_MERGE_CHK,
        ST_SPLIT_WR2,
        ST_RESULT
    } state_t;

    state_t                  state_reg, state_next;
    logic [P_W-1:0]          p_reg, p_next;
    logic signed [H_W-1:0]   hp_reg, hp_next;
    logic [H_W-1:0]          best_reg, best_next;
    logic [WORDS_W-1:0]      words_reg, words_next;
    logic                    query_reg, query_next;
    logic                    phase2_reg, phase2_next;
    logic                    oob_reg, oob_next;
    logic                    ok_reg, ok_next;
    logic [OFFS_W-1:0]       offs_reg, offs_next;
    logic [ADDR_W-1:0]       clr_reg, clr_next;
    logic [P_W-1:0]          n_reg, n_next;
    logic                    rsp_valid_reg;
    logic                    rsp_ok_reg;
    logic [OFFS_W-1:0]       rsp_offs_reg;
    logic [LARGEST_W-1:0]    rsp_larg_reg;

    logic                    ram_we, ram_re;
    logic [P_W-1:0]          waddr, raddr;
    logic [H_W-1:0]          ram_wdata, ram_rdata;
    logic signed [H_W-1:0]   rd_data;
    logic [H_W-1:0]          h_abs;
    logic [P_W-1:0]          p_after_rd;
    logic [P_W-1:0]          p_after_hp;
    logic signed [R_W-1:0]   rem;
    logic [C_W-1:0]          pw_ext;
    logic [C_W-1:0]          n_sel;
    logic [C_W-1:0]          handle_ext;
    logic                    res_load;

    ffha_ram #(
        .WIDTH (H_W),
        .DEPTH (POOL_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we && (waddr < POOL_P)),
        .waddr (waddr[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re && (raddr < POOL_P)),
        .raddr (raddr[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // A header position beyond the pool reads as the end marker.
    assign rd_data    = oob_reg ? END_MARK : $signed(ram_rdata);
    assign h_abs      = rd_data[H_W-1] ? H_W'(-rd_data) : H_W'(rd_data);
    assign p_after_rd = p_reg + P_W'(1) + P_W'(h_abs);
    assign p_after_hp = p_reg + P_W'(1) + P_W'(H_W'(hp_reg));
    assign rem        = R_W'(hp_reg) - $signed(R_W'(words_reg));

    // Pool size for init, saturated to the RAM depth.
    assign pw_ext     = C_W'(pool_words);
    assign n_sel      = (pw_ext > POOL_C) ? POOL_C : pw_ext;
    assign handle_ext = C_W'(cmd.handle);

    assign res_load = (state_reg == ST_RESULT) && (!rsp_valid_reg || rsp.ready);

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.ok            = rsp_ok_reg;
    assign rsp.block_offset  = rsp_offs_reg;
    assign rsp.largest_bytes = rsp_larg_reg;

    // Next-state and RAM control for the header walk.
    always_comb
    begin
        state_next  = state_reg;
        p_next      = p_reg;
        hp_next     = hp_reg;
        best_next   = best_reg;
        words_next  = words_reg;
        query_next  = query_reg;
        phase2_next = phase2_reg;
        oob_next    = oob_reg;
        ok_next     = ok_reg;
        offs_next   = offs_reg;
        clr_next    = clr_reg;
        n_next      = n_reg;
        cmd_pop     = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        waddr       = p_reg;
        raddr       = p_reg;
        ram_wdata   = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the RAM once, leaving one free block and the end marker.
                ram_we = 1'b1;
                waddr  = P_W'(clr_reg);
                if (clr_reg == '0)
                begin
                    ram_wdata = H_W'(POOL_WORDS - 2);
                end
                else if (clr_reg == ADDR_W'(POOL_WORDS - 1))
                begin
                    ram_wdata = END_MARK;
                end
                if (clr_reg == ADDR_W'(POOL_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + ADDR_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    ok_next     = 1'b0;
                    offs_next   = '0;
                    best_next   = '0;
                    words_next  = cmd.words;
                    phase2_next = 1'b0;
                    p_next      = '0;
                    case (cmd.mode)
                        MODE_INIT:
                        begin
                            if (n_sel >= C_W'(2))
                            begin
                                ram_we     = 1'b1;
                                waddr      = '0;
                                ram_wdata  = H_W'(n_sel - C_W'(2));
                                n_next     = P_W'(n_sel);
                                ok_next    = 1'b1;
                                state_next = ST_INIT_WR2;
                            end
                            else
                            begin
                                state_next = ST_RESULT;
                            end
                        end
                        MODE_FREE:
                        begin
                            if ((handle_ext != '0) && ((handle_ext - C_W'(1)) < POOL_C))
                            begin
                                ram_re     = 1'b1;
                                raddr      = P_W'(handle_ext - C_W'(1));
                                p_next     = P_W'(handle_ext - C_W'(1));
                                oob_next   = 1'b0;
                                state_next = ST_FREE_CHK;
                            end
                            else
                            begin
                                state_next = ST_RESULT;
                            end
                        end
                        MODE_ALLOC:
                        begin
                            query_next = 1'b0;
                            state_next = ST_WALK_RD;
                        end
                        default:
                        begin
                            query_next = 1'b1;
                            state_next = ST_WALK_RD;
                        end
                    endcase
                end
            end

            ST_INIT_WR2:
            begin
                ram_we     = 1'b1;
                waddr      = n_reg - P_W'(1);
                ram_wdata  = END_MARK;
                state_next = ST_RESULT;
            end

            ST_FREE_CHK:
            begin
                if (rd_data != END_MARK)
                begin
                    ram_we    = 1'b1;
                    waddr     = p_reg;
                    ram_wdata = H_W'(-rd_data);
                    ok_next   = 1'b1;
                end
                state_next = ST_RESULT;
            end

            ST_WALK_RD:
            begin
                ram_re     = 1'b1;
                raddr      = p_reg;
                oob_next   = (p_reg >= POOL_P);
                state_next = ST_WALK_CHK;
            end

            ST_WALK_CHK:
            begin
                if (rd_data == END_MARK)
                begin
                    if (query_reg && !phase2_reg)
                    begin
                        // Merging pass done: rescan for the largest block.
                        phase2_next = 1'b1;
                        p_next      = '0;
                        best_next   = '0;
                        state_next  = ST_WALK_RD;
                    end
                    else
                    begin
                        ok_next    = query_reg;
                        state_next = ST_RESULT;
                    end
                end
                else if (rd_data < 0)
                begin
                    p_next     = p_after_rd;
                    state_next = ST_WALK_RD;
                end
                else if (phase2_reg)
                begin
                    if (h_abs > best_reg)
                    begin
                        best_next = h_abs;
                    end
                    p_next     = p_after_rd;
                    state_next = ST_WALK_RD;
                end
                else
                begin
                    hp_next    = rd_data;
                    state_next = ST_MERGE_RD;
                end
            end

            ST_MERGE_RD:
            begin
                ram_re     = 1'b1;
                raddr      = p_after_hp;
                oob_next   = (p_after_hp >= POOL_P);
                state_next = ST_MERGE_CHK;
            end

            ST_MERGE_CHK:
            begin
                if ((rd_data != END_MARK) && (rd_data > 0))
                begin
                    // Absorb the following free block into this one.
                    hp_next    = hp_reg + H_W'(1) + rd_data;
                    ram_we     = 1'b1;
                    waddr      = p_reg;
                    ram_wdata  = H_W'(hp_reg + H_W'(1) + rd_data);
                    state_next = ST_MERGE_RD;
                end
                else if (!query_reg && !rem[R_W-1])
                begin
                    ram_we    = 1'b1;
                    waddr     = p_reg;
                    ok_next   = 1'b1;
                    offs_next = OFFS_W'(p_reg + P_W'(1));
                    if (rem > R_W'(1))
                    begin
                        ram_wdata  = H_W'(-$signed(R_W'(words_reg)));
                        state_next = ST_SPLIT_WR2;
                    end
                    else
                    begin
                        ram_wdata  = H_W'(-hp_reg);
                        state_next = ST_RESULT;
                    end
                end
                else
                begin
                    p_next     = p_after_hp;
                    state_next = ST_WALK_RD;
                end
            end

            ST_SPLIT_WR2:
            begin
                // Remainder of the split block becomes a new free block.
                ram_we     = 1'b1;
                waddr      = p_reg + P_W'(1) + P_W'(words_reg);
                ram_wdata  = H_W'(rem - R_W'(1));
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, walk registers and the response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            p_reg         <= '0;
            hp_reg        <= '0;
            best_reg      <= '0;
            words_reg     <= '0;
            query_reg     <= 1'b0;
            phase2_reg    <= 1'b0;
            oob_reg       <= 1'b0;
            ok_reg        <= 1'b0;
            offs_reg      <= '0;
            n_reg         <= '0;
            rsp_ok_reg    <= 1'b0;
            rsp_offs_reg  <= '0;
            rsp_larg_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            p_reg      <= p_next;
            hp_reg     <= hp_next;
            best_reg   <= best_next;
            words_reg  <= words_next;
            query_reg  <= query_next;
            phase2_reg <= phase2_next;
            oob_reg    <= oob_next;
            ok_reg     <= ok_next;
            offs_reg   <= offs_next;
            n_reg      <= n_next;
            if (res_load)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_ok_reg    <= ok_reg;
                rsp_offs_reg  <= query_reg ? '0 : offs_reg;
                rsp_larg_reg  <= query_reg ? LARGEST_W'({best_reg, 3'b000}) : '0;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // The response register is only loaded when the slot is free.
    `FFHA_ASSERT(a_rsp_no_overwrite, clk, rst_n, (rsp.valid && !rsp.ready) |=> $stable(rsp.ok) && $stable(rsp.block_offset), "response overwritten while stalled")
    // No command is taken from the queue during the clearing pass.
    `FFHA_ASSERT(a_no_pop_in_clear, clk, rst_n, (state_reg == ST_CLEAR) |-> !cmd_pop, "command popped during RAM clearing")
    // A command is popped only when the queue holds one.
    `FFHA_ASSERT_ALWAYS(a_pop_valid, clk, cmd_pop |-> cmd_valid, "pop from an empty command queue")
    // A loaded allocation result is presented on the following cycle.
    `FFHA_ASSERT(a_alloc_offs, clk, rst_n, (res_load && ok_reg && !query_reg && offs_reg != '0) |=> rsp.valid, "allocation result not presented")

endmodule

`default_nettype wire

FILE: src/first_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit allocator over an implicit list of block headers kept in RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Payload
//  req_ch    in         valid/ready         mode, request_bytes, handle
//  rsp_ch    out        valid/ready         ok, block_offset, largest_bytes
//  cfg       in         cfg_we (no wait)    cfg_wdata = pool size in words
//
// Init writes the first header and then the end marker; free reads the header
// and negates it. Allocate visits the headers in order, merging each free one
// with its free neighbours before trying to fit the request; the query walks the
// pool twice, merging in the first pass and seeking the largest block in the second.
// The header RAM has a single read port, one read per step. After reset a clearing
// pass formats the RAM; requests wait in the queue meanwhile. A two-entry queue and
// a registered response let the request and response sides stall independently.
//
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator_core #(
    parameter int POOL_WORDS = 4096
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    ffha_req_if.sink                         req_ch,
    ffha_rsp_if.source                       rsp_ch,
    input  wire logic                        cfg_we,
    input  wire logic [ffha_pkg::CFG_W-1:0]  cfg_wdata
);
    import ffha_pkg::*;

    logic [CFG_W-1:0] pool_words_reg;
    cmd_t             front_cmd;
    logic             front_valid;
    logic             fifo_ready;
    cmd_t             back_cmd;
    logic             back_valid;
    logic             back_pop;

    // Pool size register, taken at the next init.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_words_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            pool_words_reg <= cfg_wdata;
        end
    end

    ffha_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (fifo_ready)
    );

    ffha_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (front_cmd),
        .push_valid (front_valid),
        .push_ready (fifo_ready),
        .pop_cmd    (back_cmd),
        .pop_valid  (back_valid),
        .pop        (back_pop)
    );

    ffha_back #(
        .POOL_WORDS (POOL_WORDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (back_cmd),
        .cmd_valid  (back_valid),
        .cmd_pop    (back_pop),
        .pool_words (pool_words_reg),
        .rsp        (rsp_ch)
    );

endmodule

`default_nettype wire
